@@ hw/rtl/lav_pkg.sv @@
`timescale 1ns / 1ps

package lav_pkg;

  typedef logic signed [31:0] s32_t;
  typedef s32_t [2:0] v32_t;
  typedef logic [1:0] grp_t;

  localparam grp_t LAST_GROUP = 2'd3;

  localparam int IN_BYTES_W = 288;
  localparam int OUT_BYTES_W = 136;

  // words carried alongside each normalization
  typedef struct packed {
    v32_t eye;
    v32_t up;
    logic near;
  } zside_t;

  typedef struct packed {
    v32_t eye;
    logic near;
    v32_t z;
  } xside_t;

  typedef struct packed {
    v32_t eye;
    logic near;
    v32_t z;
    v32_t x;
  } yside_t;

endpackage

@@ hw/rtl/lav_norm.sv @@
`timescale 1ns / 1ps

module lav_norm #(
  parameter int FRAC_BITS = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][63:0]     in_vec,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic [2:0][31:0]     out_vec,
  output logic [SW-1:0]        out_side
);

  localparam int QB = FRAC_BITS + 1;
  localparam int RB = 32;

  // stage 1: magnitudes
  logic              v1;
  logic [SW-1:0]     side1;
  logic [2:0][63:0]  m1;
  logic [2:0]        neg1;
  logic [63:0]       or1;
  logic [2:0][63:0]  mag_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= in_side;
      m1    <= mag_c;
      or1   <= mag_c[0] | mag_c[1] | mag_c[2];
      for (int i = 0; i < 3; i++) neg1[i] <= in_vec[i][63];
    end
  end

  // stage 2: leading one of the largest magnitude
  logic              v2;
  logic [SW-1:0]     side2;
  logic [2:0][63:0]  m2;
  logic [2:0]        neg2;
  logic [5:0]        pos2;
  logic              zero2;
  logic [5:0]        pos_c;

  always_comb begin
    pos_c = '0;
    for (int b = 0; b < 64; b++) begin
      if (or1[b]) pos_c = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side1;
      m2    <= m1;
      neg2  <= neg1;
      pos2  <= pos_c;
      zero2 <= (or1 == 64'd0);
    end
  end

  // stage 3: scale so the largest lands in [2^30, 2^31)
  logic              v3;
  logic [SW-1:0]     side3;
  logic [2:0][30:0]  s3;
  logic [2:0]        neg3;
  logic              zero3;
  logic [2:0][63:0]  sh_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2 >= 6'd30) sh_c[i] = m2[i] >> (pos2 - 6'd30);
      else sh_c[i] = m2[i] << (6'd30 - pos2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side2;
      neg3  <= neg2;
      zero3 <= zero2;
      for (int i = 0; i < 3; i++) s3[i] <= sh_c[i][30:0];
    end
  end

  // stage 4: squares
  logic              v4;
  logic [SW-1:0]     side4;
  logic [2:0][30:0]  s4;
  logic [2:0][61:0]  sq4;
  logic [2:0]        neg4;
  logic              zero4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side3;
      s4    <= s3;
      neg4  <= neg3;
      zero4 <= zero3;
      for (int i = 0; i < 3; i++) sq4[i] <= 62'(s3[i]) * 62'(s3[i]);
    end
  end

  // square root, one result bit per stage; index 0 holds the sum
  logic              sv    [0:RB];
  logic [SW-1:0]     sside [0:RB];
  logic [2:0][30:0]  ss    [0:RB];
  logic [2:0]        sneg  [0:RB];
  logic              szero [0:RB];
  logic [63:0]       srem  [0:RB];
  logic [31:0]       sroot [0:RB];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sside[0] <= side4;
      ss[0]    <= s4;
      sneg[0]  <= neg4;
      szero[0] <= zero4;
      srem[0]  <= 64'(sq4[0]) + 64'(sq4[1]) + 64'(sq4[2]);
      sroot[0] <= '0;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int K = RB - 1 - j;
    logic [65:0] trial;
    logic        take;

    assign trial = ({34'd0, sroot[j]} << (K + 1)) + (66'd1 << (2 * K));
    assign take  = ({2'b00, srem[j]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else if (en) sv[j+1] <= sv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sside[j+1] <= sside[j];
        ss[j+1]    <= ss[j];
        sneg[j+1]  <= sneg[j];
        szero[j+1] <= szero[j];
        srem[j+1]  <= take ? (srem[j] - trial[63:0]) : srem[j];
        sroot[j+1] <= take ? (sroot[j] | (32'd1 << K)) : sroot[j];
      end
    end
  end

  // division with rounding, one quotient bit per stage; index 0 holds numerators
  logic              dv    [0:QB];
  logic [SW-1:0]     dside [0:QB];
  logic [2:0]        dneg  [0:QB];
  logic              dzero [0:QB];
  logic [31:0]       dlen  [0:QB];
  logic [2:0][63:0]  drem  [0:QB];
  logic [2:0][QB-1:0] dq   [0:QB];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= sv[RB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= sside[RB];
      dneg[0]  <= sneg[RB];
      dzero[0] <= szero[RB];
      dlen[0]  <= sroot[RB];
      dq[0]    <= '0;
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (64'(ss[RB][i]) << FRAC_BITS) + 64'(sroot[RB][31:1]);
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = FRAC_BITS - j;
    logic [63:0] dsh;

    assign dsh = 64'(dlen[j]) << K;

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside[j+1] <= dside[j];
        dneg[j+1]  <= dneg[j];
        dzero[j+1] <= dzero[j];
        dlen[j+1]  <= dlen[j];
        for (int i = 0; i < 3; i++) begin
          if (drem[j][i] >= dsh) begin
            drem[j+1][i] <= drem[j][i] - dsh;
            dq[j+1][i]   <= dq[j][i] | (QB'(1) << K);
          end else begin
            drem[j+1][i] <= drem[j][i];
            dq[j+1][i]   <= dq[j][i];
          end
        end
      end
    end
  end

  // sign and the zero vector
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= dside[QB];
      for (int i = 0; i < 3; i++) begin
        if (dzero[QB]) out_vec[i] <= '0;
        else if (dneg[QB][i]) out_vec[i] <= 32'd0 - 32'(dq[QB][i]);
        else out_vec[i] <= 32'(dq[QB][i]);
      end
    end
  end

endmodule

@@ hw/rtl/look_at_view_matrix.sv @@
`timescale 1ns / 1ps

// look-at view matrix generator
// s_axis word: eye, center and up vectors in signed fixed point with
// FRAC_BITS fraction bits. m_axis gives the 4x4 view matrix as four words,
// one row group each, tlast on the fourth. epsilon_we/epsilon write the
// threshold below which eye and center count as equal (identity result).
// a fully pipelined datapath runs three vector normalizations in a row; each
// has a 32-stage square root and a FRAC_BITS+1 stage divider.
// the output side sends one word per cycle while m_axis_tready is high, so
// one input is taken per four output words when the pipe is full; the pipe
// itself takes one word per cycle until its last stage is full.
// the four output words sit in a holding register; while the receiver stalls
// and the last stage holds a result, the whole pipe holds and s_axis_tready
// drops, nothing is lost. reset empties the pipe and sets epsilon to 1.
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               epsilon_we,
  input  logic [15:0]                        epsilon,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z
  input  logic [lav_pkg::IN_BYTES_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // group_index, elem_0, elem_1, elem_2, elem_3, zero fill
  output logic [lav_pkg::OUT_BYTES_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  logic        en;
  logic [15:0] eps;

  always_ff @(posedge clk) begin
    if (rst) eps <= 16'd1;
    else if (epsilon_we) eps <= epsilon;
  end

  // input stage: differences and the near test
  lav_pkg::v32_t    in_eye, in_ctr, in_up;
  logic [2:0][63:0] d_c;
  logic             near_c;

  always_comb begin
    near_c = 1'b1;
    for (int i = 0; i < 3; i++) begin
      in_eye[i] = s_axis_tdata[32*i +: 32];
      in_ctr[i] = s_axis_tdata[96 + 32*i +: 32];
      in_up[i]  = s_axis_tdata[192 + 32*i +: 32];
      d_c[i]    = 64'(in_eye[i]) - 64'(in_ctr[i]);
      if ((d_c[i][63] ? (64'd0 - d_c[i]) : d_c[i]) >= 64'(eps)) near_c = 1'b0;
    end
  end

  logic             v0;
  logic [2:0][63:0] d0;
  lav_pkg::zside_t  zs_in;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0         <= d_c;
      zs_in.eye  <= in_eye;
      zs_in.up   <= in_up;
      zs_in.near <= near_c;
    end
  end

  // z axis
  logic             vz;
  logic [2:0][31:0] zv;
  lav_pkg::zside_t  zs_out;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SW($bits(lav_pkg::zside_t))) u_norm_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .in_vec(d0), .in_side(zs_in),
    .out_valid(vz), .out_vec(zv), .out_side(zs_out)
  );

  // up cross z
  logic                   va;
  logic signed [63:0]     pa [0:5];
  lav_pkg::xside_t        xa;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= vz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0]   <= zs_out.up[1] * $signed(zv[2]);
      pa[1]   <= zs_out.up[2] * $signed(zv[1]);
      pa[2]   <= zs_out.up[2] * $signed(zv[0]);
      pa[3]   <= zs_out.up[0] * $signed(zv[2]);
      pa[4]   <= zs_out.up[0] * $signed(zv[1]);
      pa[5]   <= zs_out.up[1] * $signed(zv[0]);
      xa.eye  <= zs_out.eye;
      xa.near <= zs_out.near;
      xa.z    <= zv;
    end
  end

  logic             vb;
  logic [2:0][63:0] rawx;
  lav_pkg::xside_t  xs_in;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rawx[0] <= pa[0] - pa[1];
      rawx[1] <= pa[2] - pa[3];
      rawx[2] <= pa[4] - pa[5];
      xs_in   <= xa;
    end
  end

  // x axis
  logic             vx;
  logic [2:0][31:0] xv;
  lav_pkg::xside_t  xs_out;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SW($bits(lav_pkg::xside_t))) u_norm_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vb), .in_vec(rawx), .in_side(xs_in),
    .out_valid(vx), .out_vec(xv), .out_side(xs_out)
  );

  // z cross x
  logic               vc1;
  logic signed [63:0] pc [0:5];
  lav_pkg::yside_t    ya;

  always_ff @(posedge clk) begin
    if (rst) vc1 <= 1'b0;
    else if (en) vc1 <= vx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc[0]   <= xs_out.z[1] * $signed(xv[2]);
      pc[1]   <= xs_out.z[2] * $signed(xv[1]);
      pc[2]   <= xs_out.z[2] * $signed(xv[0]);
      pc[3]   <= xs_out.z[0] * $signed(xv[2]);
      pc[4]   <= xs_out.z[0] * $signed(xv[1]);
      pc[5]   <= xs_out.z[1] * $signed(xv[0]);
      ya.eye  <= xs_out.eye;
      ya.near <= xs_out.near;
      ya.z    <= xs_out.z;
      ya.x    <= xv;
    end
  end

  logic             vc2;
  logic [2:0][63:0] rawy;
  lav_pkg::yside_t  ys_in;

  always_ff @(posedge clk) begin
    if (rst) vc2 <= 1'b0;
    else if (en) vc2 <= vc1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rawy[0] <= pc[0] - pc[1];
      rawy[1] <= pc[2] - pc[3];
      rawy[2] <= pc[4] - pc[5];
      ys_in   <= ya;
    end
  end

  // y axis
  logic             vy;
  logic [2:0][31:0] yv;
  lav_pkg::yside_t  ys_out;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SW($bits(lav_pkg::yside_t))) u_norm_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vc2), .in_vec(rawy), .in_side(ys_in),
    .out_valid(vy), .out_vec(yv), .out_side(ys_out)
  );

  // translation row: products, sum with rounding offset, shift and clamp
  logic               vda;
  logic signed [63:0] pd [0:2][0:2];
  lav_pkg::v32_t      ax, ay, az;
  logic               anear;

  always_ff @(posedge clk) begin
    if (rst) vda <= 1'b0;
    else if (en) vda <= vy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd[0][i] <= ys_out.x[i] * ys_out.eye[i];
        pd[1][i] <= $signed(yv[i]) * ys_out.eye[i];
        pd[2][i] <= ys_out.z[i] * ys_out.eye[i];
      end
      ax    <= ys_out.x;
      ay    <= yv;
      az    <= ys_out.z;
      anear <= ys_out.near;
    end
  end

  logic               vdb;
  logic signed [63:0] tb [0:2];
  lav_pkg::v32_t      bx, by, bz;
  logic               bnear;

  always_ff @(posedge clk) begin
    if (rst) vdb <= 1'b0;
    else if (en) vdb <= vda;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        tb[r] <= $signed(HALF) - (pd[r][0] + pd[r][1] + pd[r][2]);
      end
      bx    <= ax;
      by    <= ay;
      bz    <= az;
      bnear <= anear;
    end
  end

  logic               vdc;
  lav_pkg::v32_t      cx, cy, cz, cdn;
  logic               cnear;
  logic signed [63:0] sr_c [0:2];

  always_comb begin
    for (int r = 0; r < 3; r++) sr_c[r] = tb[r] >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) vdc <= 1'b0;
    else if (en) vdc <= vdb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        if (sr_c[r] > 64'sd2147483647) cdn[r] <= 32'sh7fffffff;
        else if (sr_c[r] < -64'sd2147483648) cdn[r] <= 32'sh80000000;
        else cdn[r] <= sr_c[r][31:0];
      end
      cx    <= bx;
      cy    <= by;
      cz    <= bz;
      cnear <= bnear;
    end
  end

  // output holding register, sent as four words
  logic          hvalid;
  lav_pkg::grp_t cnt;
  lav_pkg::v32_t hx, hy, hz, hdn;
  logic          hnear;
  logic          hold_take;
  logic          word_done;

  assign word_done = hvalid && m_axis_tready;
  assign hold_take = vdc && (!hvalid || (word_done && cnt == lav_pkg::LAST_GROUP));
  assign en = !vdc || hold_take;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= 1'b0;
      cnt    <= '0;
    end else if (hold_take) begin
      hvalid <= 1'b1;
      cnt    <= '0;
    end else if (word_done) begin
      if (cnt == lav_pkg::LAST_GROUP) hvalid <= 1'b0;
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_take) begin
      hx    <= cx;
      hy    <= cy;
      hz    <= cz;
      hdn   <= cdn;
      hnear <= cnear;
    end
  end

  logic [3:0][31:0] elem;

  always_comb begin
    elem = '0;
    if (hnear) begin
      elem[cnt] = ONE;
    end else if (cnt == lav_pkg::LAST_GROUP) begin
      elem[0] = hdn[0];
      elem[1] = hdn[1];
      elem[2] = hdn[2];
      elem[3] = ONE;
    end else begin
      elem[0] = hx[cnt];
      elem[1] = hy[cnt];
      elem[2] = hz[cnt];
    end
  end

  assign m_axis_tvalid = hvalid;
  assign m_axis_tlast  = (cnt == lav_pkg::LAST_GROUP);
  assign m_axis_tdata  = {6'd0, elem[3], elem[2], elem[1], elem[0], cnt};

  a_last_group: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == lav_pkg::LAST_GROUP)
    else $error("tlast off the last group");

  a_group_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1)
    else $error("group sequence broken");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vdc && !en |=> vdc && hvalid)
    else $error("pipe tail lost while stalled");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    hold_take |-> !hvalid || (m_axis_tready && m_axis_tlast))
    else $error("holding register overwritten");

endmodule

@@ test/tb_look_at_view_matrix.sv @@
`timescale 1ns / 1ps

module tb_look_at_view_matrix;

  typedef logic [8:0][31:0] view_req_t;
  typedef longint vec3_t[3];
  typedef struct {
    logic [1:0]  grp;
    logic [31:0] el[4];
    logic        last;
  } row_word_t;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam longint ONE = 64'sd1 << 16;
  localparam logic [31:0] ONE_W = 32'h0001_0000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 700;

  logic clk = 0;
  logic rst = 1;
  logic epsilon_we = 0;
  logic [15:0] epsilon = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [lav_pkg::IN_BYTES_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [lav_pkg::OUT_BYTES_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  look_at_view_matrix dut (
    .clk(clk), .rst(rst),
    .epsilon_we(epsilon_we), .epsilon(epsilon),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk = ~clk;

  view_req_t pending[$];
  row_word_t rows_due[$];
  longint unsigned eps_now = 1;
  int errors = 0;
  int taken = 0;
  bit idle_on = 1;
  int quiet = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void normalize(input vec3_t v, output vec3_t u);
    longint unsigned m[3];
    longint unsigned mx = 0, sum = 0, len, q;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 16) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // translation term, rounded half up and clamped to 32 bits
  function automatic longint eye_offset(vec3_t u, vec3_t e);
    longint t;
    t = -(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]) + (64'sd1 <<< 15);
    t = t >>> 16;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t;
  endfunction

  function automatic void queue_view_rows(view_req_t r);
    vec3_t eye, d, up, x, y, z, raw;
    longint mat[4][4];
    bit near = 1;
    row_word_t w;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(r[i]));
      d[i] = eye[i] - longint'($signed(r[3 + i]));
      up[i] = longint'($signed(r[6 + i]));
      if ((d[i] < 0 ? -d[i] : d[i]) >= longint'(eps_now)) near = 0;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) mat[i][j] = 0;
    if (near) begin
      for (int i = 0; i < 4; i++) mat[i][i] = ONE;
    end else begin
      normalize(d, z);
      cross_prod(up, z, raw);
      normalize(raw, x);
      cross_prod(z, x, raw);
      normalize(raw, y);
      for (int i = 0; i < 3; i++) begin
        mat[i][0] = x[i];
        mat[i][1] = y[i];
        mat[i][2] = z[i];
      end
      mat[3][0] = eye_offset(x, eye);
      mat[3][1] = eye_offset(y, eye);
      mat[3][2] = eye_offset(z, eye);
      mat[3][3] = ONE;
    end
    for (int i = 0; i < 4; i++) begin
      w.grp = i[1:0];
      for (int j = 0; j < 4; j++) w.el[j] = mat[i][j][31:0];
      w.last = (w.grp == lav_pkg::LAST_GROUP);
      rows_due.push_back(w);
    end
  endfunction

  // sender
  int src_gap = 0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        queue_view_rows(pending.pop_front());
        taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        nv = 1;
      end else if (src_gap > 0) begin
        src_gap--;
        nv = 0;
      end else if (idle_on && pending.size() > 0 && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 18);
        nv = 0;
      end else begin
        nv = pending.size() > 0;
      end
      s_axis_tvalid <= nv;
      if (nv) s_axis_tdata <= pending[0];
    end
  end

  // receiver, with one long hold-off once 50 inputs have been taken
  int dst_gap = 0;
  bit held_once = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (!held_once && taken >= 50) begin
      held_once = 1;
      dst_gap = LONG_HOLD;
      m_axis_tready <= 0;
    end else if (dst_gap > 0) begin
      dst_gap--;
      m_axis_tready <= 0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      dst_gap = $urandom_range(0, 18);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    row_word_t w;
    logic [31:0] got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rows_due.size() == 0) begin
        $display("unexpected word %h", m_axis_tdata);
        errors++;
      end else begin
        w = rows_due.pop_front();
        if (m_axis_tdata[1:0] !== w.grp) report("group_index", m_axis_tdata[1:0], w.grp);
        for (int j = 0; j < 4; j++) begin
          got = m_axis_tdata[2 + 32 * j +: 32];
          if (got !== w.el[j]) report($sformatf("row %0d elem_%0d", w.grp, j), got, w.el[j]);
        end
        if (m_axis_tlast !== w.last) report("tlast", m_axis_tlast, w.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic void add_random(int count);
    view_req_t r;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) r[i] = rand_coord(kind == 3 ? 0 : kind);
      // eye close to center, near the threshold
      if ($urandom_range(0, 5) == 0)
        for (int i = 0; i < 3; i++)
          r[3 + i] = r[i] + $urandom_range(0, 2 * eps_now + 2) - (eps_now + 1);
      // up along the view direction
      if ($urandom_range(0, 15) == 0)
        for (int i = 0; i < 3; i++) r[6 + i] = r[i] - r[3 + i];
      pending.push_back(r);
    end
  endfunction

  task automatic drain();
    while (pending.size() > 0 || rows_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_eps(logic [15:0] v);
    @(posedge clk);
    epsilon_we <= 1;
    epsilon <= v;
    @(posedge clk);
    epsilon_we <= 0;
    eps_now = v;
  endtask

  function automatic view_req_t mk(logic [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz);
    return {uz, uy, ux, cz, cy, cx, ez, ey, ex};
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;

    // identity cases, unit axes, degenerate cross products, extremes
    pending.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(5, 6, 7, 5, 6, 7, 0, ONE_W, 0));
    pending.push_back(mk(1, 0, 0, 0, 0, 0, 0, ONE_W, 0));
    pending.push_back(mk(0, 0, 5 * ONE_W, 0, 0, 0, 0, ONE_W, 0));
    pending.push_back(mk(ONE_W, 2 * ONE_W, 3 * ONE_W, 0, 0, 0, 0, ONE_W, 0));
    pending.push_back(mk(0, 0, ONE_W, 0, 0, 0, 0, 0, ONE_W));
    pending.push_back(mk(0, 0, ONE_W, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN,
                         S32_MAX, S32_MIN, S32_MAX));
    pending.push_back(mk(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX,
                         S32_MIN, S32_MAX, S32_MIN));
    pending.push_back(mk(S32_MAX, 0, 0, S32_MIN, 0, 0, 0, S32_MAX, 0));
    pending.push_back(mk(S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, S32_MIN, S32_MIN, 1));
    pending.push_back(mk(S32_MAX, S32_MAX, S32_MAX, S32_MAX - 1, S32_MAX, S32_MAX,
                         S32_MIN, S32_MIN, S32_MIN));
    pending.push_back(mk(-1, -1, -1, 0, 0, 0, -1, -1, -1));
    pending.push_back(mk(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
                         32'hedcb_a987, 0, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 3));
    drain();

    // zero threshold: eye on center gives a zero rotation
    set_eps(16'h0000);
    pending.push_back(mk(0, 0, 0, 0, 0, 0, 0, ONE_W, 0));
    pending.push_back(mk(S32_MAX, 7, -9, S32_MAX, 7, -9, 1, 2, 3));
    pending.push_back(mk(1, 0, 0, 0, 0, 0, 0, ONE_W, 0));
    drain();

    set_eps(16'hffff);
    pending.push_back(mk(32'h0000_fffe, 0, 0, 0, 0, 0, 0, ONE_W, 0));
    pending.push_back(mk(32'h0000_ffff, 0, 0, 0, 0, 0, 0, ONE_W, 0));
    pending.push_back(mk(0, -32'sh0000_fffe, 32'h0000_fffe, 0, 0, 0, ONE_W, 0, 0));
    add_random(20);
    drain();

    // long batch, the receiver hold-off lands inside it
    set_eps(16'($urandom_range(0, 65535)));
    add_random(180);
    drain();

    set_eps(16'h0000);
    add_random(15);
    drain();

    set_eps(16'($urandom_range(0, 255)));
    add_random(15);
    drain();

    // closing stretch runs at full rate
    idle_on = 0;
    set_eps(16'h0001);
    add_random(20);
    drain();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
